>>> src/shabh_pkg.sv
// ----------------------------------------------------------------------------
// shabh_pkg
// types, constants and round functions shared by the sha-256 block hash unit
// ----------------------------------------------------------------------------
`default_nettype none

package shabh_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        msg_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // queued word with its classification
  typedef struct packed {
    logic [31:0] word;
    logic        msg_done;
  } q_item_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big0(input word_t a);
    return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  endfunction

  function automatic word_t big1(input word_t e);
    return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  endfunction

  function automatic word_t small0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b0, x[31:3]};
  endfunction

  function automatic word_t small1(input word_t y);
    return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ {10'b0, y[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/sha256_block_hash_unit.sv
// ----------------------------------------------------------------------------
// sha256_block_hash_unit
// sha-256 compression over an already padded message, one word per item
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o with in_data_i holding one 32-bit
// big-endian message word and an end flag. every 16 words form a block; the
// end flag counts only on the word that completes a block.
// output channel: out_valid_o / out_ready_i with out_data_o holding one
// digest word, its index 0..7 and a last flag on index 7.
// the compression core runs one round per cycle while it has words: a block
// takes 64 rounds and the chaining add before the core takes words of the
// next block, which wait in a small queue meanwhile. the first digest word
// appears after the remaining rounds and the chaining add of the last block;
// the eight words then leave one per cycle while out_ready_i is high.
// while the receiver stalls, the digest holds and the core waits; words keep
// entering the queue until it fills, then in_ready_o drops.
// reset empties the queue, clears the word position and loads the chaining
// words with the standard initial values.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_block_hash_unit #(
  parameter int QueueDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  shabh_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output shabh_pkg::out_item_t out_data_o
);
  import shabh_pkg::*;

  logic    push, full, pop, q_valid;
  q_item_t push_data, pop_data;

  shabh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  shabh_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_data)
  );

  shabh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // core never takes a word from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("word taken from empty queue");

  // no words are consumed while a digest is going out
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !pop)
    else $error("word consumed during digest output");

  // digest output stops after the last digest word of a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.digest_last) |=> !out_valid_o)
    else $error("digest output runs past the last word");

  // digest words go out in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.digest_last) |=>
      (out_valid_o && out_data_o.digest_index == $past(out_data_o.digest_index) + 3'd1))
    else $error("digest index out of order");

endmodule

`default_nettype wire

>>> src/shabh_front.sv
// ----------------------------------------------------------------------------
// shabh_front
// accepts message words, tracks the word position and marks block-ending
// words that close the message
// ----------------------------------------------------------------------------
`default_nettype none

module shabh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  shabh_pkg::in_item_t in_data_i,
  output logic                push_o,
  output shabh_pkg::q_item_t  push_data_o,
  input  logic                full_i
);
  import shabh_pkg::*;

  logic [3:0] count_q, count_d;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // end mark only counts on the word that completes a block
  assign push_data_o.word     = in_data_i.msg_word;
  assign push_data_o.msg_done = in_data_i.msg_end && (count_q == 4'hf);

  assign count_d = push_o ? count_q + 4'd1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> src/shabh_queue.sv
// ----------------------------------------------------------------------------
// shabh_queue
// short word queue between the front and the compression core
// ----------------------------------------------------------------------------
`default_nettype none

module shabh_queue #(
  parameter int Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  shabh_pkg::q_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output shabh_pkg::q_item_t pop_data_o
);
  import shabh_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_item_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> src/shabh_core.sv
// ----------------------------------------------------------------------------
// shabh_core
// one sha-256 round per cycle while message words are at hand, with a rolling
// schedule window, chaining update and digest output register
// ----------------------------------------------------------------------------
`default_nettype none

module shabh_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  shabh_pkg::q_item_t   q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output shabh_pkg::out_item_t out_data_o
);
  import shabh_pkg::*;

  typedef enum logic [1:0] {
    StRound,
    StFinal,
    StEmit
  } state_e;

  state_e     state_q;
  logic [5:0] round_q;
  logic       done_q;
  logic [2:0] idx_q;
  logic       out_valid_q;
  word_t      out_word_q;
  word_t      v_q [8];
  word_t      chain_q [8];
  word_t      w_q [16];

  logic  need_word, advance;
  word_t sched_w, wt, ch, maj, t1, t2;
  word_t chain_new [8];

  assign need_word = (round_q[5:4] == 2'b00);
  assign advance   = (state_q == StRound) && (!need_word || q_valid_i);
  assign q_pop_o   = (state_q == StRound) && need_word && q_valid_i;

  assign sched_w = small1(w_q[14]) + w_q[9] + small0(w_q[1]) + w_q[0];
  assign wt      = need_word ? q_data_i.word : sched_w;
  assign ch      = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj     = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1      = v_q[7] + big1(v_q[4]) + ch + round_k(round_q) + wt;
  assign t2      = big0(v_q[0]) + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_new[i] = chain_q[i] + v_q[i];
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.digest_word  = out_word_q;
  assign out_data_o.digest_index = idx_q;
  assign out_data_o.digest_last  = (idx_q == 3'd7);

  // schedule window
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRound;
      round_q     <= 6'd0;
      done_q      <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        v_q[i]     <= InitHash[i];
        chain_q[i] <= InitHash[i];
      end
    end else begin
      unique case (state_q)
        StRound: begin
          if (advance) begin
            v_q[7] <= v_q[6];
            v_q[6] <= v_q[5];
            v_q[5] <= v_q[4];
            v_q[4] <= v_q[3] + t1;
            v_q[3] <= v_q[2];
            v_q[2] <= v_q[1];
            v_q[1] <= v_q[0];
            v_q[0] <= t1 + t2;
            round_q <= round_q + 6'd1;
            if (round_q == 6'd15) begin
              done_q <= q_data_i.msg_done;
            end
            if (round_q == 6'd63) begin
              state_q <= StFinal;
            end
          end
        end
        StFinal: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_new[i];
            v_q[i]     <= chain_new[i];
          end
          if (done_q) begin
            state_q     <= StEmit;
            out_valid_q <= 1'b1;
            out_word_q  <= chain_new[0];
            idx_q       <= 3'd0;
          end else begin
            state_q <= StRound;
          end
        end
        StEmit: begin
          if (out_ready_i) begin
            if (idx_q == 3'd7) begin
              out_valid_q <= 1'b0;
              state_q     <= StRound;
              for (int i = 0; i < 8; i++) begin
                v_q[i]     <= InitHash[i];
                chain_q[i] <= InitHash[i];
              end
            end else begin
              idx_q      <= idx_q + 3'd1;
              out_word_q <= chain_q[idx_q + 3'd1];
            end
          end
        end
        default: begin
          state_q <= StRound;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sha-256 block hash unit
// ----------------------------------------------------------------------------
// padded messages go in as whole 16-word blocks, one word per item. An inline
// sha-256 predictor folds each accepted word into its own chaining words and
// queues the eight digest words when a marked word closes a block. A monitor
// compares every digest item against that queue, field by field. Both sides
// idle in random bursts, with calm stretches and a calm tail.
// ----------------------------------------------------------------------------
module tb_top;
  import shabh_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int StimItems  = 220;
  localparam int CalmTail   = 32;

  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  msg_word_q [$];
  out_item_t digest_q [$];
  word_t     hash_chain [8];
  word_t     block_buf [16];
  logic [3:0] word_pos;

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned in_odds = 0;
  int unsigned out_odds = 0;
  logic        calm;
  out_item_t   exp_item;

  sha256_block_hash_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  function automatic word_t ror(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // fold one accepted word into the running hash, queue a digest on message end
  function automatic void absorb_word(in_item_t item);
    word_t     sched [64];
    word_t     v [8];
    word_t     t1;
    word_t     t2;
    word_t     x;
    word_t     y;
    out_item_t res;
    block_buf[word_pos] = item.msg_word;
    if (word_pos != 4'd15) begin
      word_pos = word_pos + 4'd1;
      return;
    end
    word_pos = '0;
    for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
    for (int i = 16; i < 64; i++) begin
      x = sched[i-15];
      y = sched[i-2];
      sched[i] = sched[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + sched[i-7]
               + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + sched[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
    if (item.msg_end) begin
      for (int j = 0; j < 8; j++) begin
        res.digest_word  = hash_chain[j];
        res.digest_index = 3'(j);
        res.digest_last  = (j == 7);
        digest_q.push_back(res);
      end
      for (int i = 0; i < 8; i++) hash_chain[i] = HashInit[i];
    end
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // one message of whole blocks; stray end marks inside are noise
  function automatic void queue_message(int unsigned nblk);
    in_item_t item;
    for (int i = 0; i < nblk * 16; i++) begin
      item.msg_word = rand_word();
      item.msg_end  = (i == nblk * 16 - 1) ? 1'b1 : ($urandom_range(0, 9) == 0);
      msg_word_q.push_back(item);
    end
  endfunction

  assign calm = (msg_word_q.size() < CalmTail);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt[5:0] == 6'd0) begin
      in_odds  <= $urandom_range(0, 2);
      out_odds <= $urandom_range(0, 2);
    end
    if (cycle_cnt == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) absorb_word(in_data);
      if (!(in_valid && !in_ready)) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && in_odds != 0 &&
                     $urandom_range(0, in_odds == 1 ? 11 : 3) == 0) begin
          in_gap   <= $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (msg_word_q.size() != 0) begin
          in_data  <= msg_word_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // digest monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < 10)
            $display("unexpected digest item: word %h index %0d last %b",
                     out_data.digest_word, out_data.digest_index, out_data.digest_last);
        end else begin
          exp_item = digest_q.pop_front();
          if (out_data !== exp_item) begin
            fail_cnt <= fail_cnt + 1;
            if (fail_cnt < 10)
              $display("digest mismatch: exp word %h index %0d last %b, got word %h index %0d last %b",
                       exp_item.digest_word, exp_item.digest_index, exp_item.digest_last,
                       out_data.digest_word, out_data.digest_index, out_data.digest_last);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && out_odds != 0 &&
                   $urandom_range(0, out_odds == 1 ? 11 : 3) == 0) begin
        out_gap   <= $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    in_item_t item;
    for (int i = 0; i < 8; i++) hash_chain[i] = HashInit[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    word_pos = '0;

    // extreme words, end marks inside the block that must be ignored
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: item.msg_word = 32'h00000000;
        1: item.msg_word = 32'hffffffff;
        2: item.msg_word = 32'h80000000;
        default: item.msg_word = 32'h00000001;
      endcase
      item.msg_end = (i % 2 == 1) || (i == 15);
      msg_word_q.push_back(item);
    end
    // mostly one-block messages, some spanning several blocks
    while (msg_word_q.size() < StimItems)
      queue_message(($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (msg_word_q.size() != 0 || in_valid || digest_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> sha256_block_hash_unit.f
src/shabh_pkg.sv
src/shabh_front.sv
src/shabh_queue.sv
src/shabh_core.sv
src/sha256_block_hash_unit.sv
dv/tb_top.sv
